// File: rtl/irfpd_pkg.sv
// Shared types and constants for the IR frame pulse decoder.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package irfpd_pkg;

  // Field widths
  localparam int unsigned LenW     = 16;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned IdxOutW  = 4;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Default frame length in bytes
  localparam int unsigned FrameBytesDef = 14;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegHeaderMin = 3'd0;
  localparam logic [CfgIdxW-1:0] RegHeaderMax = 3'd1;
  localparam logic [CfgIdxW-1:0] RegGapMin    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegGapMax    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegZeroMin   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegBitSplit  = 3'd5;
  localparam logic [CfgIdxW-1:0] RegOneMax    = 3'd6;

  // Register reset values
  localparam logic [LenW-1:0] HeaderMinRst = 16'd2500;
  localparam logic [LenW-1:0] HeaderMaxRst = 16'd3500;
  localparam logic [LenW-1:0] GapMinRst    = 16'd4000;
  localparam logic [LenW-1:0] GapMaxRst    = 16'd5000;
  localparam logic [LenW-1:0] ZeroMinRst   = 16'd300;
  localparam logic [LenW-1:0] BitSplitRst  = 16'd1000;
  localparam logic [LenW-1:0] OneMaxRst    = 16'd2000;

  // Controller states
  typedef enum logic [2:0] {
    StIdle,
    StHead1,
    StHead2,
    StHead3,
    StData,
    StDumpRd,
    StDumpWr
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic clr_bits;  // accepted gap: restart bit counter
    logic take_bit;  // shift one data bit in
    logic bit_val;   // value of that bit
    logic idx_clr;   // restart dump index
    logic rd_en;     // read frame store at dump index
    logic load_out;  // load output register, advance dump index
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic mark;
    logic hdr_ok;
    logic gap_ok;
    logic zero_ok;
    logic one_ok;
    logic frame_done;  // next data bit completes the frame
    logic idx_last;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// File: rtl/irfpd_if.sv
// Handshake channel interfaces of the IR frame pulse decoder.
// Depends on irfpd_pkg for the field widths.
`default_nettype none

interface irfpd_pulse_if;
  import irfpd_pkg::*;
  logic            valid;
  logic            ready;
  logic            pulse_level;
  logic [LenW-1:0] pulse_length;

  modport source (output valid, output pulse_level, output pulse_length, input ready);
  modport sink   (input valid, input pulse_level, input pulse_length, output ready);
endinterface

interface irfpd_byte_if;
  import irfpd_pkg::*;
  logic               valid;
  logic               ready;
  logic [ByteW-1:0]   frame_byte;
  logic [IdxOutW-1:0] byte_index;
  logic               last_byte;

  modport source (output valid, output frame_byte, output byte_index, output last_byte,
                  input ready);
  modport sink   (input valid, input frame_byte, input byte_index, input last_byte,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/ir_frame_pulse_decoder_top.sv
// Top level of the IR frame pulse decoder: controller plus datapath.
// Depends on irfpd_pkg, irfpd_if, irfpd_ctrl and irfpd_dp.
//
//   channel   dir  handshake     payload
//   pulse_i   in   valid/ready   pulse_level, pulse_length
//   byte_o    out  valid/ready   frame_byte, byte_index, last_byte
//   cfg_*     in   cfg_we_i      cfg_idx_i, cfg_wdata_i (no read-back)
//
// Pulses may follow back to back while ready is high.
// After the final data bit the frame store is read out byte by byte: a store
// read, then an output load, which waits while byte_o stalls.
// Pulse input is held off (ready low) during that readout only.
// rst_ni is asynchronous, active low; it restores register defaults and idle.
`default_nettype none

module ir_frame_pulse_decoder_top #(
  parameter int unsigned FrameBytes = irfpd_pkg::FrameBytesDef
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire  [irfpd_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire  [irfpd_pkg::CfgDataW-1:0]   cfg_wdata_i,
  irfpd_pulse_if.sink                      pulse_i,
  irfpd_byte_if.source                     byte_o
);
  import irfpd_pkg::*;

  cmd_t    cmd;
  status_t st;

  irfpd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (pulse_i.valid),
    .in_ready_o (pulse_i.ready),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  irfpd_dp #(
    .FrameBytes (FrameBytes)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .pulse_level_i  (pulse_i.pulse_level),
    .pulse_length_i (pulse_i.pulse_length),
    .cmd_i          (cmd),
    .st_o           (st),
    .out_valid_o    (byte_o.valid),
    .out_ready_i    (byte_o.ready),
    .frame_byte_o   (byte_o.frame_byte),
    .byte_index_o   (byte_o.byte_index),
    .last_byte_o    (byte_o.last_byte)
  );

endmodule

`default_nettype wire

// File: rtl/irfpd_ctrl.sv
// Phase state machine of the IR frame pulse decoder.
// Depends on irfpd_pkg; drives the datapath through cmd_t, reads status_t.
`default_nettype none

module irfpd_ctrl (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  irfpd_pkg::status_t st_i,
  output irfpd_pkg::cmd_t    cmd_o
);
  import irfpd_pkg::*;

  state_e state_q, state_d;
  logic   acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Input is taken in every state except while the frame is dumped
  assign in_ready_o = (state_q != StDumpRd) && (state_q != StDumpWr);
  assign acc        = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (acc) state_d = (st_i.mark && st_i.hdr_ok) ? StHead1 : StIdle;
      end
      StHead1: begin
        if (acc) state_d = (!st_i.mark && st_i.hdr_ok) ? StHead2 : StIdle;
      end
      StHead2: begin
        if (acc) state_d = (st_i.mark && st_i.hdr_ok) ? StHead3 : StIdle;
      end
      StHead3: begin
        if (acc) begin
          if (!st_i.mark && st_i.gap_ok) begin
            state_d        = StData;
            cmd_o.clr_bits = 1'b1;
          end else begin
            state_d = StIdle;
          end
        end
      end
      StData: begin
        // marks and stray spaces are ignored
        if (acc && !st_i.mark && (st_i.zero_ok || st_i.one_ok)) begin
          cmd_o.take_bit = 1'b1;
          cmd_o.bit_val  = st_i.one_ok;
          if (st_i.frame_done) begin
            cmd_o.idx_clr = 1'b1;
            state_d       = StDumpRd;
          end
        end
      end
      StDumpRd: begin
        cmd_o.rd_en = 1'b1;
        state_d     = StDumpWr;
      end
      StDumpWr: begin
        if (st_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = st_i.idx_last ? StIdle : StDumpRd;
        end
      end
      default: state_d = StIdle;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/irfpd_dp.sv
// Datapath of the IR frame pulse decoder: registers, window compares,
// bit assembly, frame store and output register. Depends on irfpd_pkg.
`default_nettype none

module irfpd_dp #(
  parameter int unsigned FrameBytes = irfpd_pkg::FrameBytesDef
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                cfg_we_i,
  input  wire  [irfpd_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire  [irfpd_pkg::CfgDataW-1:0]     cfg_wdata_i,
  input  wire                                pulse_level_i,
  input  wire  [irfpd_pkg::LenW-1:0]         pulse_length_i,
  input  irfpd_pkg::cmd_t                    cmd_i,
  output irfpd_pkg::status_t                 st_o,
  output logic                               out_valid_o,
  input  wire                                out_ready_i,
  output logic [irfpd_pkg::ByteW-1:0]        frame_byte_o,
  output logic [irfpd_pkg::IdxOutW-1:0]      byte_index_o,
  output logic                               last_byte_o
);
  import irfpd_pkg::*;

  localparam int unsigned TotalBits = FrameBytes * 8;
  localparam int unsigned CntW      = $clog2(TotalBits + 1);
  localparam int unsigned AddrW     = (FrameBytes > 1) ? $clog2(FrameBytes) : 1;
  localparam logic [CntW-1:0]  LastBit  = CntW'(TotalBits - 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(FrameBytes - 1);

  // Configuration registers
  logic [LenW-1:0] header_min_q, header_max_q, gap_min_q, gap_max_q;
  logic [LenW-1:0] zero_min_q, bit_split_q, one_max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_min_q <= HeaderMinRst;
      header_max_q <= HeaderMaxRst;
      gap_min_q    <= GapMinRst;
      gap_max_q    <= GapMaxRst;
      zero_min_q   <= ZeroMinRst;
      bit_split_q  <= BitSplitRst;
      one_max_q    <= OneMaxRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegHeaderMin: header_min_q <= cfg_wdata_i;
        RegHeaderMax: header_max_q <= cfg_wdata_i;
        RegGapMin:    gap_min_q    <= cfg_wdata_i;
        RegGapMax:    gap_max_q    <= cfg_wdata_i;
        RegZeroMin:   zero_min_q   <= cfg_wdata_i;
        RegBitSplit:  bit_split_q  <= cfg_wdata_i;
        RegOneMax:    one_max_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Bit counter and byte assembly
  logic [CntW-1:0]  bit_cnt_q;
  logic [ByteW-1:0] acc_q;
  logic [ByteW-1:0] acc_next;
  logic             byte_full;

  assign acc_next  = {acc_q[ByteW-2:0], cmd_i.bit_val};
  assign byte_full = (bit_cnt_q[2:0] == 3'd7);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_cnt_q <= '0;
    end else if (cmd_i.clr_bits) begin
      bit_cnt_q <= '0;
    end else if (cmd_i.take_bit) begin
      bit_cnt_q <= bit_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_bit) acc_q <= acc_next;
  end

  // Frame store: each byte is written whole once its eighth bit arrives
  logic [ByteW-1:0] store_mem [FrameBytes];
  logic [ByteW-1:0] rd_data_q;
  logic [AddrW-1:0] idx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_bit && byte_full) store_mem[bit_cnt_q[3 +: AddrW]] <= acc_next;
    if (cmd_i.rd_en) rd_data_q <= store_mem[idx_q];
  end

  // Dump index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.idx_clr) begin
      idx_q <= '0;
    end else if (cmd_i.load_out) begin
      idx_q <= idx_q + 1'b1;
    end
  end

  // Output register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      frame_byte_o <= rd_data_q;
      byte_index_o <= IdxOutW'(idx_q);
      last_byte_o  <= (idx_q == LastAddr);
    end
  end

  assign out_valid_o = out_valid_q;

  // Window compares and status
  always_comb begin
    st_o.mark       = pulse_level_i;
    st_o.hdr_ok     = (pulse_length_i >= header_min_q) && (pulse_length_i <= header_max_q);
    st_o.gap_ok     = (pulse_length_i >= gap_min_q) && (pulse_length_i <= gap_max_q);
    st_o.zero_ok    = (pulse_length_i >= zero_min_q) && (pulse_length_i <= bit_split_q);
    st_o.one_ok     = (pulse_length_i > bit_split_q) && (pulse_length_i <= one_max_q);
    st_o.frame_done = (bit_cnt_q == LastBit);
    st_o.idx_last   = (idx_q == LastAddr);
    st_o.out_free   = !out_valid_q || out_ready_i;
  end

endmodule

`default_nettype wire
